### design/ucd_scan_pkg.sv
package ucd_scan_pkg;

    // Blob buffer limit and the width of the saturating byte position
    localparam int MAX_BLOB_BYTES = 256;
    localparam int POS_W          = $clog2(MAX_BLOB_BYTES + 1);

    // Descriptor fields and codes
    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] IF_DESC_MIN_LEN     = 8'd9;
    localparam logic [7:0] MIN_DESC_LEN        = 8'd2;
    localparam logic [7:0] OFF_LENGTH          = 8'd0;
    localparam logic [7:0] OFF_TYPE            = 8'd1;
    localparam logic [7:0] OFF_IF_CLASS        = 8'd5;
    localparam logic [7:0] OFF_IF_PROTOCOL     = 8'd7;

    localparam logic [7:0] CLASS_NONE   = 8'h00;
    localparam logic [7:0] CLASS_AUDIO  = 8'h01;
    localparam logic [7:0] CLASS_CDC    = 8'h02;
    localparam logic [7:0] CLASS_HID    = 8'h03;
    localparam logic [7:0] CLASS_MSC    = 8'h08;
    localparam logic [7:0] CLASS_CDC_DATA = 8'h0A;
    localparam logic [7:0] CLASS_WIRELESS = 8'hE0;
    localparam logic [7:0] CLASS_VENDOR = 8'hFF;

    localparam logic [7:0] HID_PROTO_KBD   = 8'd1;
    localparam logic [7:0] HID_PROTO_MOUSE = 8'd2;

    // Class flag bit positions
    localparam int FLAG_KBD    = 0;
    localparam int FLAG_MOUSE  = 1;
    localparam int FLAG_HID    = 2;
    localparam int FLAG_MSC    = 3;
    localparam int FLAG_VENDOR = 4;
    localparam int FLAG_AUDIO  = 5;
    localparam int FLAG_NET    = 6;
    localparam int FLAGS_W     = 7;

    localparam int IF_CNT_W = 5;
    localparam logic [IF_CNT_W-1:0] IF_CNT_MAX = '1;

    localparam int KBD_BUS_W = 7;

    typedef logic [FLAGS_W-1:0] t_flags;

    // Risk levels
    localparam logic [1:0] RISK_NONE    = 2'd0;
    localparam logic [1:0] RISK_SUSPECT = 2'd1;
    localparam logic [1:0] RISK_DANGER  = 2'd2;

    // Reason codes
    localparam logic [3:0] RSN_KBD_STORAGE = 4'd0;
    localparam logic [3:0] RSN_KBD_VENDOR  = 4'd1;
    localparam logic [3:0] RSN_DISGUISED   = 4'd2;
    localparam logic [3:0] RSN_MULTI_KBD   = 4'd3;
    localparam logic [3:0] RSN_HUB         = 4'd4;
    localparam logic [3:0] RSN_KBD         = 4'd5;
    localparam logic [3:0] RSN_POINTER     = 4'd6;
    localparam logic [3:0] RSN_HID         = 4'd7;
    localparam logic [3:0] RSN_STORAGE     = 4'd8;
    localparam logic [3:0] RSN_AUDIO       = 4'd9;
    localparam logic [3:0] RSN_NET         = 4'd10;
    localparam logic [3:0] RSN_GENERIC     = 4'd11;

endpackage

### design/usb_config_descriptor_threat_scan.sv
// Channel   Direction  Handshake            Word
// input     in         i_valid / o_stall    i_desc_byte, i_last_byte, i_device_class,
//                                           i_device_is_hub
// output    out        o_valid / i_stall    o_risk_level, o_reason_code,
//                                           o_interface_count, o_has_keyboard,
//                                           o_class_flag_bits
// config    in         i_cfg_we             i_cfg_wdata (keyboards on bus)
//
// One input word per cycle while o_stall is low; the parse state updates in the cycle the byte is taken.
// A verdict appears on the output register in the cycle after its last byte is taken.
// The per-byte state update is computed combinationally and closed through the parse registers.
// Input stalls only while a verdict is held and the output side stalls.
// Synchronous active-low reset clears parse state, output valid and the config register.
module usb_config_descriptor_threat_scan (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_desc_byte,
    input  logic       i_last_byte,
    input  logic [7:0] i_device_class,
    input  logic       i_device_is_hub,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_risk_level,
    output logic [3:0] o_reason_code,
    output logic [4:0] o_interface_count,
    output logic       o_has_keyboard,
    output logic [6:0] o_class_flag_bits
);

    logic [ucd_scan_pkg::KBD_BUS_W-1:0] r_kbd_bus;

    logic [7:0]                        r_off, n_off;
    logic [7:0]                        r_len, n_len;
    logic [7:0]                        r_type, n_type;
    logic [7:0]                        r_cls, n_cls;
    logic [7:0]                        r_prot, n_prot;
    logic [ucd_scan_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                              r_stopped, n_stopped;
    ucd_scan_pkg::t_flags              r_flags, n_flags;
    logic [ucd_scan_pkg::IF_CNT_W-1:0] r_count, n_count;

    logic                              r_out_valid;
    logic [1:0]                        r_risk, n_risk;
    logic [3:0]                        r_reason, n_reason;
    logic [ucd_scan_pkg::IF_CNT_W-1:0] r_out_count;
    ucd_scan_pkg::t_flags              r_out_flags;

    logic w_accept;
    logic w_parse;
    logic w_short;
    logic w_end;
    logic w_commit;
    logic w_kbd;
    logic [8:0] w_off_inc;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_parse  = (r_pos < ucd_scan_pkg::POS_W'(ucd_scan_pkg::MAX_BLOB_BYTES)) & ~r_stopped;

    // Per-byte descriptor walk
    always_comb begin
        n_len  = (r_off == ucd_scan_pkg::OFF_LENGTH) ? i_desc_byte : r_len;
        n_type = (r_off == ucd_scan_pkg::OFF_TYPE) ? i_desc_byte : r_type;
        n_cls  = (r_off == ucd_scan_pkg::OFF_IF_CLASS) ? i_desc_byte : r_cls;
        n_prot = (r_off == ucd_scan_pkg::OFF_IF_PROTOCOL) ? i_desc_byte : r_prot;
        w_short = (r_off == ucd_scan_pkg::OFF_LENGTH) &&
                  (i_desc_byte < ucd_scan_pkg::MIN_DESC_LEN);
        w_off_inc = {1'b0, r_off} + 9'd1;
        w_end    = w_off_inc >= {1'b0, n_len};
        w_commit = w_end && (n_type == ucd_scan_pkg::DESC_TYPE_INTERFACE) &&
                   (n_len >= ucd_scan_pkg::IF_DESC_MIN_LEN);
        n_off     = r_off;
        n_stopped = r_stopped;
        n_flags   = r_flags;
        n_count   = r_count;
        n_pos     = r_pos;

        if (r_pos < ucd_scan_pkg::POS_W'(ucd_scan_pkg::MAX_BLOB_BYTES)) begin
            n_pos = r_pos + 1'b1;
        end

        if (w_parse) begin
            if (w_short) begin
                // hold the fields, offset, flags and count, stop walking for the rest of the blob
                n_stopped = 1'b1;
                n_len     = r_len;
                n_type    = r_type;
                n_cls     = r_cls;
                n_prot    = r_prot;
            end else begin
                n_off = w_end ? 8'd0 : w_off_inc[7:0];
                if (w_commit) begin
                    if (r_count != ucd_scan_pkg::IF_CNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    if (n_cls == ucd_scan_pkg::CLASS_HID) begin
                        if (n_prot == ucd_scan_pkg::HID_PROTO_KBD) begin
                            n_flags[ucd_scan_pkg::FLAG_KBD] = 1'b1;
                        end else if (n_prot == ucd_scan_pkg::HID_PROTO_MOUSE) begin
                            n_flags[ucd_scan_pkg::FLAG_MOUSE] = 1'b1;
                        end else begin
                            n_flags[ucd_scan_pkg::FLAG_HID] = 1'b1;
                        end
                    end else if (n_cls == ucd_scan_pkg::CLASS_MSC) begin
                        n_flags[ucd_scan_pkg::FLAG_MSC] = 1'b1;
                    end else if (n_cls == ucd_scan_pkg::CLASS_VENDOR) begin
                        n_flags[ucd_scan_pkg::FLAG_VENDOR] = 1'b1;
                    end else if (n_cls == ucd_scan_pkg::CLASS_AUDIO) begin
                        n_flags[ucd_scan_pkg::FLAG_AUDIO] = 1'b1;
                    end else if (n_cls inside {ucd_scan_pkg::CLASS_CDC,
                                               ucd_scan_pkg::CLASS_CDC_DATA,
                                               ucd_scan_pkg::CLASS_WIRELESS}) begin
                        n_flags[ucd_scan_pkg::FLAG_NET] = 1'b1;
                    end
                end
            end
        end else begin
            n_len  = r_len;
            n_type = r_type;
            n_cls  = r_cls;
            n_prot = r_prot;
        end
    end

    // Verdict from the flags as they stand after this byte
    always_comb begin
        w_kbd    = n_flags[ucd_scan_pkg::FLAG_KBD];
        n_risk   = ucd_scan_pkg::RISK_NONE;
        n_reason = ucd_scan_pkg::RSN_GENERIC;
        if (w_kbd && n_flags[ucd_scan_pkg::FLAG_MSC]) begin
            n_risk   = ucd_scan_pkg::RISK_DANGER;
            n_reason = ucd_scan_pkg::RSN_KBD_STORAGE;
        end else if (w_kbd && n_flags[ucd_scan_pkg::FLAG_VENDOR]) begin
            n_risk   = ucd_scan_pkg::RISK_DANGER;
            n_reason = ucd_scan_pkg::RSN_KBD_VENDOR;
        end else if (w_kbd && (i_device_class != ucd_scan_pkg::CLASS_NONE) &&
                     (i_device_class != ucd_scan_pkg::CLASS_HID)) begin
            n_risk   = ucd_scan_pkg::RISK_SUSPECT;
            n_reason = ucd_scan_pkg::RSN_DISGUISED;
        end else if (w_kbd && (r_kbd_bus > ucd_scan_pkg::KBD_BUS_W'(1))) begin
            n_risk   = ucd_scan_pkg::RISK_SUSPECT;
            n_reason = ucd_scan_pkg::RSN_MULTI_KBD;
        end else if (i_device_is_hub) begin
            n_reason = ucd_scan_pkg::RSN_HUB;
        end else if (w_kbd) begin
            n_reason = ucd_scan_pkg::RSN_KBD;
        end else if (n_flags[ucd_scan_pkg::FLAG_MOUSE]) begin
            n_reason = ucd_scan_pkg::RSN_POINTER;
        end else if (n_flags[ucd_scan_pkg::FLAG_HID]) begin
            n_reason = ucd_scan_pkg::RSN_HID;
        end else if (n_flags[ucd_scan_pkg::FLAG_MSC]) begin
            n_reason = ucd_scan_pkg::RSN_STORAGE;
        end else if (n_flags[ucd_scan_pkg::FLAG_AUDIO]) begin
            n_reason = ucd_scan_pkg::RSN_AUDIO;
        end else if (n_flags[ucd_scan_pkg::FLAG_NET]) begin
            n_reason = ucd_scan_pkg::RSN_NET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbd_bus <= '0;
        end else if (i_cfg_we) begin
            r_kbd_bus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_byte)) begin
            // clear on reset and after every blob
            r_off     <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_cls     <= '0;
            r_prot    <= '0;
            r_pos     <= '0;
            r_stopped <= 1'b0;
            r_flags   <= '0;
            r_count   <= '0;
        end else if (w_accept) begin
            r_off     <= n_off;
            r_len     <= n_len;
            r_type    <= n_type;
            r_cls     <= n_cls;
            r_prot    <= n_prot;
            r_pos     <= n_pos;
            r_stopped <= n_stopped;
            r_flags   <= n_flags;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_risk      <= n_risk;
            r_reason    <= n_reason;
            r_out_count <= n_count;
            r_out_flags <= n_flags;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_risk_level      = r_risk;
    assign o_reason_code     = r_reason;
    assign o_interface_count = r_out_count;
    assign o_has_keyboard    = r_out_flags[ucd_scan_pkg::FLAG_KBD];
    assign o_class_flag_bits = r_out_flags;

    a_new_verdict_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && i_stall)) |-> $past(w_accept && i_last_byte))
        else $error("verdict appeared without a last byte");

    a_clear_after_blob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept && i_last_byte) |->
            (r_pos == '0 && r_flags == '0 && r_count == '0 && !r_stopped))
        else $error("parse state not cleared after blob");

    a_danger_needs_kbd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_risk != ucd_scan_pkg::RISK_NONE) |->
            r_out_flags[ucd_scan_pkg::FLAG_KBD])
        else $error("nonzero risk without keyboard flag");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= ucd_scan_pkg::POS_W'(ucd_scan_pkg::MAX_BLOB_BYTES))
        else $error("blob position beyond buffer limit");

endmodule
